// ===== hdl/qfdo_pkg.sv =====
// ----------------------------------------------------------------------------
// qfdo_pkg
// Shared types and constants of the Q-filtered disturbance observer: field
// widths, configuration register indexes and the controller command bundle.
// ----------------------------------------------------------------------------
package qfdo_pkg;

    // Field widths.
    localparam int unsigned MEAS_W  = 16;
    localparam int unsigned STAGE_W = 32;
    localparam int unsigned ALPHA_W = 16;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CIDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_DIFF_GAIN = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_GAIN_INV  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_ALPHA     = 2'd2;

    // Datapath operation that the controller selects for one cycle.
    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_GI,
        STEP_DG,
        STEP_RLO,
        STEP_RHI,
        STEP_SUMAR,
        STEP_F,
        STEP_MS,
        STEP_S,
        STEP_CLR
    } t_step;

    // Command bundle from the controller to the datapath.
    typedef struct packed {
        logic  load_in;
        t_step step;
        logic  load_out;
    } t_cmd;

endpackage

// ===== hdl/qfdo_ctrl.sv =====
// ----------------------------------------------------------------------------
// qfdo_ctrl
// Controller of the observer: sequences the shared multiplier through the
// step computation, handles reset items and the output valid flag.
// ----------------------------------------------------------------------------
module qfdo_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_func,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    output qfdo_pkg::t_cmd o_cmd
);
    import qfdo_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GI,
        ST_DG,
        ST_RLO,
        ST_RHI,
        ST_SUMAR,
        ST_F,
        ST_MS,
        ST_S,
        ST_CLR,
        ST_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_o_valid;
    logic   n_o_valid;
    logic   w_in_acc;
    logic   w_out_free;
    logic   w_load_out;

    // Handshake qualifiers.
    assign w_in_acc   = i_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_load_out = (r_state == ST_OUT) && w_out_free;

    // Next state and output valid.
    always_comb begin
        n_state   = r_state;
        n_o_valid = r_o_valid && i_stall;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = i_func ? ST_CLR : ST_GI;
                end
            end
            ST_GI:    n_state = ST_DG;
            ST_DG:    n_state = ST_RLO;
            ST_RLO:   n_state = ST_RHI;
            ST_RHI:   n_state = ST_SUMAR;
            ST_SUMAR: n_state = ST_F;
            ST_F:     n_state = ST_MS;
            ST_MS:    n_state = ST_S;
            ST_S:     n_state = ST_OUT;
            ST_CLR:   n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_free) begin
                    n_state   = ST_IDLE;
                    n_o_valid = 1'b1;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    // Datapath command for the current state.
    always_comb begin
        o_cmd.load_in  = w_in_acc;
        o_cmd.load_out = w_load_out;
        case (r_state)
            ST_GI:    o_cmd.step = STEP_GI;
            ST_DG:    o_cmd.step = STEP_DG;
            ST_RLO:   o_cmd.step = STEP_RLO;
            ST_RHI:   o_cmd.step = STEP_RHI;
            ST_SUMAR: o_cmd.step = STEP_SUMAR;
            ST_F:     o_cmd.step = STEP_F;
            ST_MS:    o_cmd.step = STEP_MS;
            ST_S:     o_cmd.step = STEP_S;
            ST_CLR:   o_cmd.step = STEP_CLR;
            default:  o_cmd.step = STEP_NONE;
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_o_valid;

`ifndef NO_ASSERTIONS
    // A reset transaction goes straight to clearing, a step starts the sequence.
    a_reset_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_func) |=> (r_state == ST_CLR))
        else $error("reset transaction did not enter the clear state");
    a_step_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_func) |=> (r_state == ST_GI))
        else $error("step transaction did not start the multiply sequence");
    // A result leaving the sequence is always published next cycle when free.
    a_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && !r_o_valid) |=> (r_o_valid && r_state == ST_IDLE))
        else $error("finished result was not published");
    // The second stage update is always followed by the output state.
    a_s_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_S) |=> (r_state == ST_OUT))
        else $error("sequence skipped the output state");
`endif

endmodule

// ===== hdl/qfdo_datapath.sv =====
// ----------------------------------------------------------------------------
// qfdo_datapath
// Datapath of the observer: configuration registers, observer state, one
// shared 33x25 signed multiplier with a registered product, accumulators and
// the output data register.
// ----------------------------------------------------------------------------
module qfdo_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [qfdo_pkg::CIDX_W-1:0]          i_cfg_index,
    input  logic [qfdo_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic signed [qfdo_pkg::MEAS_W-1:0]   i_measurement,
    input  logic signed [qfdo_pkg::MEAS_W-1:0]   i_applied_input,
    input  qfdo_pkg::t_cmd                       i_cmd,
    output logic signed [qfdo_pkg::STAGE_W-1:0]  o_disturbance_estimate
);
    import qfdo_pkg::*;

    // Clamp a wide two's complement value to the 32-bit stage range.
    function automatic logic [STAGE_W-1:0] sat32(input logic [51:0] v);
        logic [20:0] hi;
        begin
            hi = v[51:31];
            if ((hi == 21'h000000) || (hi == 21'h1FFFFF)) begin
                sat32 = v[31:0];
            end else if (v[51]) begin
                sat32 = 32'h8000_0000;
            end else begin
                sat32 = 32'h7FFF_FFFF;
            end
        end
    endfunction

    // Configuration and observer state.
    logic [31:0] r_dg;
    logic [31:0] r_gi;
    logic [15:0] r_alpha;
    logic [15:0] r_prev;
    logic [31:0] r_fs;
    logic [31:0] r_ss;

    // Latched transaction and intermediate values.
    logic [15:0] r_meas;
    logic [15:0] r_uin;
    logic signed [57:0] r_prod;
    logic [47:0] r_res;
    logic [49:0] r_acc;
    logic [39:0] r_arlo;
    logic [63:0] r_ar;
    logic [31:0] r_out;

    logic signed [32:0] w_mul_a;
    logic signed [24:0] w_mul_b;
    logic signed [57:0] w_mul_p;
    logic [16:0] w_d;
    logic [32:0] w_fs_diff;
    logic [47:0] w_uin_q;
    logic [51:0] w_f;
    logic [49:0] w_rp;
    logic [51:0] w_s;

    // Measurement difference and stage difference, both exact.
    assign w_d       = {r_meas[15], r_meas} - {r_prev[15], r_prev};
    assign w_fs_diff = {r_fs[31], r_fs} - {r_ss[31], r_ss};
    assign w_uin_q   = {{16{r_uin[15]}}, r_uin, 16'h0000};

    // Operand selection for the shared multiplier.
    always_comb begin
        case (i_cmd.step)
            STEP_GI: begin
                w_mul_a = signed'({r_gi[31], r_gi});
                w_mul_b = signed'({{9{r_prev[15]}}, r_prev});
            end
            STEP_DG: begin
                w_mul_a = signed'({r_dg[31], r_dg});
                w_mul_b = signed'({{8{w_d[16]}}, w_d});
            end
            STEP_RLO: begin
                w_mul_a = signed'({9'h000, r_res[23:0]});
                w_mul_b = signed'({9'h000, r_alpha});
            end
            STEP_RHI: begin
                w_mul_a = signed'({{9{r_res[47]}}, r_res[47:24]});
                w_mul_b = signed'({9'h000, r_alpha});
            end
            STEP_MS: begin
                w_mul_a = signed'(w_fs_diff);
                w_mul_b = signed'({9'h000, r_alpha});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // First stage sum: accumulator plus rounded alpha times residual.
    assign w_f  = {{2{r_acc[49]}}, r_acc} + {{4{r_ar[63]}}, r_ar[63:16]};
    // Second stage sum: stage plus rounded alpha times stage difference.
    assign w_rp = r_prod[49:0] + 50'd32768;
    assign w_s  = {{20{r_ss[31]}}, r_ss} + {{18{w_rp[49]}}, w_rp[49:16]};

    // Configuration and observer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dg    <= '0;
            r_gi    <= '0;
            r_alpha <= '0;
            r_prev  <= '0;
            r_fs    <= '0;
            r_ss    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DIFF_GAIN: r_dg    <= i_cfg_data;
                    CFG_GAIN_INV:  r_gi    <= i_cfg_data;
                    CFG_ALPHA:     r_alpha <= i_cfg_data[ALPHA_W-1:0];
                    default:       ;
                endcase
            end
            case (i_cmd.step)
                STEP_F: r_fs <= sat32(w_f);
                STEP_S: begin
                    r_ss   <= sat32(w_s);
                    r_prev <= r_meas;
                end
                STEP_CLR: begin
                    r_prev <= r_meas;
                    r_fs   <= '0;
                    r_ss   <= '0;
                end
                default: ;
            endcase
        end
    end

    // Transaction capture, product register and intermediate accumulators.
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_p;
        if (i_cmd.load_in) begin
            r_meas <= i_measurement;
            r_uin  <= i_applied_input;
        end
        case (i_cmd.step)
            // Residual from the inverse-model product.
            STEP_DG:    r_res <= r_prod[47:0] - w_uin_q - {{16{r_fs[31]}}, r_fs};
            // First stage plus gain times measurement difference.
            STEP_RLO:   r_acc <= r_prod[49:0] + {{18{r_fs[31]}}, r_fs};
            STEP_RHI:   r_arlo <= r_prod[39:0];
            // Recombine the two partial products and add the rounding offset.
            STEP_SUMAR: r_ar <= {r_prod[39:0], 24'h000000} + {24'h000000, r_arlo}
                                + 64'd32768;
            default:    ;
        endcase
        if (i_cmd.load_out) begin
            r_out <= r_ss;
        end
    end

    assign o_disturbance_estimate = signed'(r_out);

endmodule

// ===== hdl/q_filtered_disturbance_observer_core.sv =====
// ----------------------------------------------------------------------------
// q_filtered_disturbance_observer_core
// Top level of the Q-filtered disturbance observer for a first-order model.
// ----------------------------------------------------------------------------
// A step transaction runs from acceptance through every step until the block
// accepts the next transaction: the single shared 33x25 multiplier is used
// five times in sequence (gain inverse times previous measurement, difference
// gain times measurement difference, alpha times the residual in two halves,
// alpha times the stage difference), with a register after each product and
// separate steps for the rounding and saturating adds. A reset transaction
// goes from the clear step to the output step. The result lands in an output
// register, so the input side is free again while that result waits; only a
// new result that finds the output register still full and stalled holds the
// sequence in its last step. Configuration registers take effect at once and
// must be written only while no transaction is in progress.
// ----------------------------------------------------------------------------
module q_filtered_disturbance_observer_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [qfdo_pkg::CIDX_W-1:0]          i_cfg_index,
    input  logic [qfdo_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_func,
    input  logic signed [qfdo_pkg::MEAS_W-1:0]   i_measurement,
    input  logic signed [qfdo_pkg::MEAS_W-1:0]   i_applied_input,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [qfdo_pkg::STAGE_W-1:0]  o_disturbance_estimate
);
    import qfdo_pkg::*;

    t_cmd w_cmd;

    // Sequencer.
    qfdo_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    // Arithmetic and state.
    qfdo_datapath u_datapath (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_measurement          (i_measurement),
        .i_applied_input        (i_applied_input),
        .i_cmd                  (w_cmd),
        .o_disturbance_estimate (o_disturbance_estimate)
    );

endmodule
